// ===== rtl/min_priority_queue_macros.svh =====
// ---------------------------------------------------------------------------
// min_priority_queue_macros.svh
// assertion macros used by the priority queue rtl
// ---------------------------------------------------------------------------
`ifndef MIN_PRIORITY_QUEUE_MACROS_SVH
`define MIN_PRIORITY_QUEUE_MACROS_SVH

// property checked at every clock edge outside reset
`define MPQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("priority queue check failed");

// implication: antecedent now, consequent in the next cycle
`define MPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("priority queue sequence check failed");

`endif

// ===== rtl/mpq_pkg.sv =====
// ---------------------------------------------------------------------------
// mpq_pkg
// constants, codes and types of the min priority queue
// ---------------------------------------------------------------------------
package mpq_pkg;

  localparam int CAPACITY  = 16;
  localparam int KEY_WIDTH = 32;
  localparam int COUNT_W   = $clog2(CAPACITY + 1);
  localparam int OUT_W     = 32;

  // operation codes
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  // error codes
  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_POP_EMPTY = 2'd1;
  localparam logic [1:0] ERR_PUSH_FULL = 2'd2;

  // contents of one cell
  typedef struct packed {
    logic                        valid;
    logic signed [KEY_WIDTH-1:0] key;
  } slot_t;

  // command broadcast to every cell
  typedef struct packed {
    logic                        push;
    logic                        pop;
    logic signed [KEY_WIDTH-1:0] key;
  } cmd_t;

endpackage

// ===== rtl/mpq_req_if.sv =====
// ---------------------------------------------------------------------------
// mpq_req_if
// request channel: push or pop with a key
// ---------------------------------------------------------------------------
interface mpq_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 mode;
  logic signed [mpq_pkg::OUT_W-1:0]     key_in;

  modport source (output valid, output mode, output key_in, input ready);
  modport sink   (input valid, input mode, input key_in, output ready);
endinterface

// ===== rtl/mpq_rsp_if.sv =====
// ---------------------------------------------------------------------------
// mpq_rsp_if
// response channel: popped key, head key, count and status
// ---------------------------------------------------------------------------
interface mpq_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [mpq_pkg::OUT_W-1:0]  popped_key;
  logic signed [mpq_pkg::OUT_W-1:0]  smallest_key;
  logic [mpq_pkg::COUNT_W-1:0]       held_count;
  logic                              is_empty;
  logic [1:0]                        error_code;

  modport source (output valid, output popped_key, output smallest_key,
                  output held_count, output is_empty, output error_code,
                  input ready);
  modport sink   (input valid, input popped_key, input smallest_key,
                  input held_count, input is_empty, input error_code,
                  output ready);
endinterface

// ===== rtl/mpq_cell.sv =====
// ---------------------------------------------------------------------------
// mpq_cell
// one slot of the sorted row; shifts right on push, left on pop
// ---------------------------------------------------------------------------
module mpq_cell (
  input  logic           clk,
  input  logic           rst,
  input  mpq_pkg::cmd_t  cmd,
  input  mpq_pkg::slot_t left,
  input  logic           left_gt,
  input  mpq_pkg::slot_t right,
  output mpq_pkg::slot_t slot,
  output logic           gt
);

  mpq_pkg::slot_t slot_next;

  // this slot is free or holds a key above the pushed one
  assign gt = !slot.valid || (slot.key > cmd.key);

  // next contents
  always_comb begin
    slot_next = slot;
    if (cmd.push) begin
      if (gt) begin
        if (left_gt) begin
          slot_next = left;
        end else begin
          slot_next.valid = 1'b1;
          slot_next.key   = cmd.key;
        end
      end
    end else if (cmd.pop) begin
      slot_next = right;
    end
  end

  // occupancy flag is reset, the key payload is not
  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else begin
      slot.valid <= slot_next.valid;
    end
    slot.key <= slot_next.key;
  end

endmodule

// ===== rtl/min_priority_queue.sv =====
// ---------------------------------------------------------------------------
// min_priority_queue
// bounded min priority queue built as a sorted row of cells
// ---------------------------------------------------------------------------
// The queue holds up to CAPACITY signed keys in a row of cells kept in
// ascending order, the smallest at the head. A push compares the new key
// against every cell at once and each cell above the insertion point shifts
// one place along; a pop takes the head and the whole row shifts back. One
// request beat is taken per cycle, and its response beat appears in the
// output register on the next cycle; the request side stalls only while that
// register is full and not drained. A pop on an empty queue returns zero with
// error code 1, a push on a full queue drops the key with error code 2.
// No clearing pass runs after reset.
// ---------------------------------------------------------------------------
`include "min_priority_queue_macros.svh"

module min_priority_queue (
  input  logic       clk,
  input  logic       rst,
  mpq_req_if.sink    req,
  mpq_rsp_if.source  rsp
);

  localparam int N = mpq_pkg::CAPACITY;

  mpq_pkg::slot_t               slots [N];
  logic [N-1:0]                 gts;
  logic [N-1:0]                 valid_vec;
  mpq_pkg::cmd_t                cmd;
  logic [mpq_pkg::COUNT_W-1:0]  count;
  logic [mpq_pkg::COUNT_W-1:0]  count_next;
  logic                         accept;
  logic                         full;
  logic                         empty;
  logic [1:0]                   err;
  logic signed [mpq_pkg::KEY_WIDTH-1:0] new_key;
  logic signed [mpq_pkg::KEY_WIDTH-1:0] head_next;
  logic signed [mpq_pkg::KEY_WIDTH-1:0] popped;

  // handshake
  assign accept    = req.valid && req.ready;
  assign req.ready = !rsp.valid || rsp.ready;

  assign full    = (count == mpq_pkg::COUNT_W'(N));
  assign empty   = (count == '0);
  assign new_key = req.key_in[mpq_pkg::KEY_WIDTH-1:0];

  // command to the row
  always_comb begin
    cmd.push = accept && (req.mode == mpq_pkg::MODE_PUSH) && !full;
    cmd.pop  = accept && (req.mode == mpq_pkg::MODE_POP) && !empty;
    cmd.key  = new_key;
  end

  // row of cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    mpq_pkg::slot_t l_slot;
    mpq_pkg::slot_t r_slot;
    logic           l_gt;

    if (i == 0) begin : g_head
      assign l_slot = '0;
      assign l_gt   = 1'b0;
    end else begin : g_mid
      assign l_slot = slots[i-1];
      assign l_gt   = gts[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign r_slot = '0;
    end else begin : g_body
      assign r_slot = slots[i+1];
    end

    mpq_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .left    (l_slot),
      .left_gt (l_gt),
      .right   (r_slot),
      .slot    (slots[i]),
      .gt      (gts[i])
    );

    assign valid_vec[i] = slots[i].valid;
  end

  // step result: count, head after the step, error
  always_comb begin
    count_next = count;
    head_next  = slots[0].valid ? slots[0].key : '0;
    popped     = '0;
    err        = mpq_pkg::ERR_OK;
    if (req.mode == mpq_pkg::MODE_PUSH) begin
      if (full) begin
        err = mpq_pkg::ERR_PUSH_FULL;
      end else begin
        count_next = count + 1'b1;
        if (!slots[0].valid || (new_key < slots[0].key)) begin
          head_next = new_key;
        end
      end
    end else begin
      if (empty) begin
        err = mpq_pkg::ERR_POP_EMPTY;
      end else begin
        count_next = count - 1'b1;
        popped     = slots[0].key;
        head_next  = slots[1].valid ? slots[1].key : '0;
      end
    end
  end

  // key count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  // response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.popped_key   <= mpq_pkg::OUT_W'(popped);
      rsp.smallest_key <= mpq_pkg::OUT_W'(head_next);
      rsp.held_count   <= count_next;
      rsp.is_empty     <= (count_next == '0);
      rsp.error_code   <= err;
    end
  end

  // checks
  `MPQ_ASSERT(a_count_matches, count == mpq_pkg::COUNT_W'($countones(valid_vec)))
  `MPQ_ASSERT(a_valid_packed, (valid_vec & (valid_vec + 1'b1)) == '0)
  `MPQ_ASSERT_NEXT(a_pop_empty_err, accept && (req.mode == mpq_pkg::MODE_POP) && empty, rsp.valid && (rsp.error_code == mpq_pkg::ERR_POP_EMPTY))
  for (genvar j = 0; j < N - 1; j++) begin : g_chk
    `MPQ_ASSERT(a_sorted, !slots[j+1].valid || (slots[j].key <= slots[j+1].key))
  end

endmodule

// ===== bench/mpq_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// mpq_checker
// watches both channels of the priority queue, predicts the response beat of
// every accepted request from a sorted copy of the held keys and compares it
// field by field with the response beat the queue returns
// ---------------------------------------------------------------------------
module mpq_checker (
  input  logic clk,
  input  logic rst,
  mpq_req_if   req,
  mpq_rsp_if   rsp,
  output int   mismatches,
  output int   awaiting
);

  typedef struct packed {
    logic signed [mpq_pkg::OUT_W-1:0] popped_key;
    logic signed [mpq_pkg::OUT_W-1:0] smallest_key;
    logic [mpq_pkg::COUNT_W-1:0]      held_count;
    logic                             is_empty;
    logic [1:0]                       error_code;
  } reply_t;

  // held keys in ascending order, the head is the next key to leave
  logic signed [mpq_pkg::KEY_WIDTH-1:0] held_keys[$];
  reply_t                               due_replies[$];
  int                                   fail_total  = 0;
  int                                   reply_index = 0;

  // apply one request to the held keys and work out its response
  function automatic reply_t predict_reply(input logic mode,
                                           input logic signed [mpq_pkg::OUT_W-1:0] key_in);
    reply_t                               r;
    logic signed [mpq_pkg::KEY_WIDTH-1:0] k;
    int                                   slot;
    r    = '0;
    k    = key_in[mpq_pkg::KEY_WIDTH-1:0];
    slot = 0;
    if (mode == mpq_pkg::MODE_PUSH) begin
      if (held_keys.size() >= mpq_pkg::CAPACITY) begin
        r.error_code = mpq_pkg::ERR_PUSH_FULL;
      end else begin
        // equal keys are interchangeable, so any slot among them will do
        while (slot < held_keys.size() && held_keys[slot] <= k) slot++;
        held_keys.insert(slot, k);
      end
    end else if (held_keys.size() == 0) begin
      r.error_code = mpq_pkg::ERR_POP_EMPTY;
    end else begin
      k            = held_keys.pop_front();
      r.popped_key = mpq_pkg::OUT_W'(k);
    end
    if (held_keys.size() != 0) r.smallest_key = mpq_pkg::OUT_W'(held_keys[0]);
    r.held_count = mpq_pkg::COUNT_W'(held_keys.size());
    r.is_empty   = (held_keys.size() == 0);
    return r;
  endfunction

  // request beats feed the prediction, response beats are checked in order
  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (!rst) begin
      if (req.valid && req.ready) begin
        due_replies.push_back(predict_reply(req.mode, req.key_in));
      end
      if (rsp.valid && rsp.ready) begin
        got.popped_key   = rsp.popped_key;
        got.smallest_key = rsp.smallest_key;
        got.held_count   = rsp.held_count;
        got.is_empty     = rsp.is_empty;
        got.error_code   = rsp.error_code;
        if (due_replies.size() == 0) begin
          fail_total++;
          if (fail_total <= 10) begin
            $display("response beat %0d with nothing outstanding: popped=%0d smallest=%0d "
                     , reply_index, got.popped_key, got.smallest_key,
                     "count=%0d empty=%0b err=%0d",
                     got.held_count, got.is_empty, got.error_code);
          end
        end else begin
          want = due_replies.pop_front();
          if (want !== got) begin
            fail_total++;
            if (fail_total <= 10) begin
              $display("response beat %0d mismatch at %0t", reply_index, $realtime);
              $display("  expected popped=%0d smallest=%0d count=%0d empty=%0b err=%0d",
                       want.popped_key, want.smallest_key, want.held_count,
                       want.is_empty, want.error_code);
              $display("  actual   popped=%0d smallest=%0d count=%0d empty=%0b err=%0d",
                       got.popped_key, got.smallest_key, got.held_count,
                       got.is_empty, got.error_code);
            end
          end
        end
        reply_index++;
      end
    end
    mismatches <= fail_total;
    awaiting   <= due_replies.size();
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// drives push and pop beats into the min priority queue, first the corner
// keys and both error cases, then random phases that lean towards filling,
// towards draining or neither, while the response side stalls on patterns of its own
// ---------------------------------------------------------------------------
module tb_top;

  localparam int ITEM_TARGET = 1250;
  localparam int DRAIN_EVERY = 300;
  localparam int LONG_HOLD   = 120;
  localparam int TAIL_CYCLES = 8;
  localparam int TIMEOUT_NS  = 4_000_000;

  logic clk          = 1'b0;
  logic rst          = 1'b1;
  logic hold_off_due = 1'b0;
  int   mismatches;
  int   awaiting;
  int   sent         = 0;

  // extremes, duplicates and alternating bit patterns
  logic signed [mpq_pkg::OUT_W-1:0] corner_keys[16] = '{
    32'sh7fff_ffff, 32'sh8000_0000, 32'sd0,         -32'sd1,
    32'sd1,         32'sd7,         32'sd7,         -32'sd7,
    32'sh8000_0001, 32'sh7fff_fffe, 32'sd100,       -32'sd100,
    32'sd7,         32'sd0,         32'sh5555_5555, 32'shaaaa_aaaa
  };

  mpq_req_if req_bus ();
  mpq_rsp_if rsp_bus ();

  min_priority_queue u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  mpq_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_bus),
    .rsp        (rsp_bus),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  always #6 clk = ~clk;

  // offer one beat and hold it until the queue takes it
  task automatic send_beat(input logic mode,
                           input logic signed [mpq_pkg::OUT_W-1:0] key);
    req_bus.valid  <= 1'b1;
    req_bus.mode   <= mode;
    req_bus.key_in <= key;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    sent++;
  endtask

  task automatic idle_for(input int cycles);
    req_bus.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // one edge first so the last accepted beat is already counted
  task automatic wait_for_drain();
    req_bus.valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  // random keys half the time, with extremes and a narrow band for duplicates
  function automatic logic signed [mpq_pkg::OUT_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2, 3, 4: return $signed(mpq_pkg::OUT_W'($urandom_range(0, 15))) - 32'sd8;
      default: return $signed($urandom);
    endcase
  endfunction

  // request side
  initial begin : stimulus
    int   push_pct;
    int   phase_items;
    int   burst;
    int   p;
    int   next_drain;
    logic mode;
    req_bus.valid  <= 1'b0;
    req_bus.mode   <= mpq_pkg::MODE_PUSH;
    req_bus.key_in <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // pop on empty, fill with corner keys, push on full, then pop some back
    send_beat(mpq_pkg::MODE_POP, 32'sh1234_5678);
    foreach (corner_keys[i]) send_beat(mpq_pkg::MODE_PUSH, corner_keys[i]);
    send_beat(mpq_pkg::MODE_PUSH, 32'sd3);
    repeat (6) send_beat(mpq_pkg::MODE_POP, $signed($urandom));
    wait_for_drain();

    // random phases; the response side takes one long hold at the start
    hold_off_due <= 1'b1;
    next_drain   = sent + DRAIN_EVERY;
    while (sent < ITEM_TARGET) begin
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 50;
        default: push_pct = 15;
      endcase
      phase_items = $urandom_range(10, 60);
      p           = 0;
      while (p < phase_items) begin
        burst = $urandom_range(1, 16);
        repeat (burst) begin
          mode = ($urandom_range(0, 99) < push_pct) ? mpq_pkg::MODE_PUSH : mpq_pkg::MODE_POP;
          send_beat(mode, pick_key());
        end
        p += burst;
        if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 8));
      end
      if (sent >= next_drain) begin
        wait_for_drain();
        next_drain = sent + DRAIN_EVERY;
      end
    end

    // wrap up
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // response side stalls in phases of random kind and length
  initial begin : drain_side
    int  kind;
    int  span;
    int  c;
    bit  hold_done;
    hold_done = 1'b0;
    rsp_bus.ready <= 1'b0;
    wait (rst == 1'b0);
    forever begin
      kind = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      for (c = 0; c < span; c++) begin
        @(posedge clk);
        // one long hold so the output register fills and the input stalls
        if (hold_off_due && !hold_done) begin
          hold_done = 1'b1;
          rsp_bus.ready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
        end
        case (kind)
          0:       rsp_bus.ready <= 1'b1;
          1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
          2:       rsp_bus.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_bus.ready <= (c % 3 != 0);
        endcase
      end
    end
  end

  // watchdog
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule
